// ===== rtl/amt_pkg.sv =====
// ============================================================================
// amt_pkg - shared definitions for the adaptive mean threshold
// Sizes, register indices, reset values and the pipeline stage record.
// ============================================================================
package amt_pkg;

    // Maximum image geometry and window side
    localparam int MAX_WINDOW = 15;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int K_W    = 4;
    localparam int DIM_W  = 11;
    localparam int OFF_W  = 9;
    localparam int CSUM_W = 12;
    localparam int WSUM_W = 16;
    localparam int KK_W   = 2 * K_W;
    localparam int PROD_W = OFF_W + 1 + KK_W + 1;

    // Line store geometry: one row of MAX_WIDTH entries per window row
    localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Register indices
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_OFFSET  = 2'd3;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [K_W-1:0]   RST_WINDOW_SIZE  = 4'd11;
    localparam logic [OFF_W-1:0] RST_MEAN_OFFSET  = 9'd2;

    // Output levels
    localparam logic [PIX_W-1:0] BIN_HIGH = 8'd255;
    localparam logic [PIX_W-1:0] BIN_LOW  = 8'd0;

    // Compare stage record
    typedef struct packed {
        logic              res;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [PIX_W-1:0]  centre;
        logic [WSUM_W-1:0] wsum;
    } amt_cmp_t;

endpackage

// ===== rtl/adaptive_mean_threshold.sv =====
// ============================================================================
// adaptive_mean_threshold - streaming adaptive mean binarisation
// Takes one 8-bit pixel per transaction in raster order and, for every pixel
// whose K x K neighbourhood lies inside the image, returns 255 when the centre
// exceeds the local mean less mean_offset, else 0, together with the centre's
// row and column; tlast marks the result caused by the last pixel of a frame.
// Border pixels give no result. Sustained rate is one pixel per clock while
// the output is not stalled; each result passes stage 1 and the compare stage
// to the output register. The rate is set by the single read-modify-write per
// pixel on the column sum memory and the line store, both read in the accept
// cycle and written back as the pixel leaves the first stage, with bypass of
// the just-written entry. Writing any register restarts the frame at row 0,
// column 0. No clearing pass after reset.
// ============================================================================
module adaptive_mean_threshold (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [amt_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] pixel
    // Result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [amt_pkg::M_TDATA_W-1:0]     m_tdata,   // [9:0] center_row,
                                                         // [19:10] center_col,
                                                         // [27:20] binary_value,
                                                         // [31:28] zero
    output logic                              m_tlast,   // frame_last
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [amt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [amt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------------
    // Configuration registers. Writes are always taken; a write to a known
    // register also restarts the frame position.
    // ------------------------------------------------------------------------
    logic [amt_pkg::DIM_W-1:0]        width_reg;
    logic [amt_pkg::DIM_W-1:0]        height_reg;
    logic [amt_pkg::K_W-1:0]          ksize_reg;
    logic signed [amt_pkg::OFF_W-1:0] offset_reg;
    logic                             cfg_hit;

    assign cfg_ready = 1'b1;

    always_comb begin
        case (cfg_index)
            amt_pkg::REG_IMAGE_WIDTH,
            amt_pkg::REG_IMAGE_HEIGHT,
            amt_pkg::REG_WINDOW_SIZE,
            amt_pkg::REG_MEAN_OFFSET: cfg_hit = cfg_valid;
            default:                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= amt_pkg::RST_IMAGE_WIDTH;
            height_reg <= amt_pkg::RST_IMAGE_HEIGHT;
            ksize_reg  <= amt_pkg::RST_WINDOW_SIZE;
            offset_reg <= amt_pkg::RST_MEAN_OFFSET;
        end else if (cfg_valid) begin
            case (cfg_index)
                amt_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                amt_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                amt_pkg::REG_WINDOW_SIZE:  ksize_reg  <= cfg_data[amt_pkg::K_W-1:0];
                amt_pkg::REG_MEAN_OFFSET:  offset_reg <= cfg_data[amt_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Clamped geometry: zero reads as one, oversize saturates.
    // ------------------------------------------------------------------------
    logic [amt_pkg::DIM_W-1:0] width_m1_full;
    logic [amt_pkg::DIM_W-1:0] height_m1_full;
    logic [amt_pkg::COL_W-1:0] w_last;
    logic [amt_pkg::ROW_W-1:0] h_last;
    logic [amt_pkg::K_W-1:0]   k_val;
    logic [amt_pkg::K_W-1:0]   k_m1;
    logic [amt_pkg::K_W-1:0]   cen_dist;   // rows/cols from window edge to centre
    logic [amt_pkg::KK_W-1:0]  k_sq;

    assign width_m1_full  = width_reg - amt_pkg::DIM_W'(1);
    assign height_m1_full = height_reg - amt_pkg::DIM_W'(1);

    always_comb begin
        if (width_reg == '0) begin
            w_last = '0;
        end else if (width_reg > amt_pkg::DIM_W'(amt_pkg::MAX_WIDTH)) begin
            w_last = amt_pkg::COL_W'(amt_pkg::MAX_WIDTH - 1);
        end else begin
            w_last = width_m1_full[amt_pkg::COL_W-1:0];
        end

        if (height_reg == '0) begin
            h_last = '0;
        end else if (height_reg > amt_pkg::DIM_W'(amt_pkg::MAX_HEIGHT)) begin
            h_last = amt_pkg::ROW_W'(amt_pkg::MAX_HEIGHT - 1);
        end else begin
            h_last = height_m1_full[amt_pkg::ROW_W-1:0];
        end

        if (ksize_reg == '0) begin
            k_val = amt_pkg::K_W'(1);
        end else if (ksize_reg > amt_pkg::K_W'(amt_pkg::MAX_WINDOW)) begin
            k_val = amt_pkg::K_W'(amt_pkg::MAX_WINDOW);
        end else begin
            k_val = ksize_reg;
        end
    end

    assign k_m1     = k_val - amt_pkg::K_W'(1);
    assign cen_dist = k_m1 >> 1;
    assign k_sq     = amt_pkg::KK_W'(k_val) * amt_pkg::KK_W'(k_val);

    // ------------------------------------------------------------------------
    // Pipeline handshake. Stage 1 holds memory read data, the compare stage
    // holds the window sum, and the output register holds the result.
    // ------------------------------------------------------------------------
    logic                 s1_v_reg;
    logic                 s2_v_reg;
    logic                 out_v_reg;
    amt_pkg::amt_cmp_t    s2_reg;
    amt_pkg::amt_cmp_t    s2_next;
    logic                 out_free;
    logic                 s2_leave;
    logic                 s2_free;
    logic                 s1_xfer;
    logic                 accept;

    assign out_free = !out_v_reg || m_tready;
    assign s2_leave = s2_v_reg && (!s2_reg.res || out_free);
    assign s2_free  = !s2_v_reg || s2_leave;
    assign s1_xfer  = s1_v_reg && s2_free;
    assign s_tready = !s1_v_reg || s1_xfer;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Position of the next pixel: row, column and both taken modulo K.
    // ------------------------------------------------------------------------
    logic [amt_pkg::ROW_W-1:0] row_reg,  row_next;
    logic [amt_pkg::COL_W-1:0] col_reg,  col_next;
    logic [amt_pkg::K_W-1:0]   rmod_reg, rmod_next;
    logic [amt_pkg::K_W-1:0]   cmod_reg, cmod_next;

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        rmod_next = rmod_reg;
        cmod_next = cmod_reg;
        if (cfg_hit) begin
            row_next  = '0;
            col_next  = '0;
            rmod_next = '0;
            cmod_next = '0;
        end else if (accept) begin
            if (col_reg == w_last) begin
                col_next  = '0;
                cmod_next = '0;
                if (row_reg == h_last) begin
                    row_next  = '0;
                    rmod_next = '0;
                end else begin
                    row_next  = row_reg + amt_pkg::ROW_W'(1);
                    rmod_next = (rmod_reg == k_m1) ? '0 : rmod_reg + amt_pkg::K_W'(1);
                end
            end else begin
                col_next  = col_reg + amt_pkg::COL_W'(1);
                cmod_next = (cmod_reg == k_m1) ? '0 : cmod_reg + amt_pkg::K_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            rmod_reg <= '0;
            cmod_reg <= '0;
        end else begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            rmod_reg <= rmod_next;
            cmod_reg <= cmod_next;
        end
    end

    // ------------------------------------------------------------------------
    // Accept cycle: addresses for the old pixel of this slot and for the
    // window centre, both in the line store.
    // ------------------------------------------------------------------------
    logic [amt_pkg::LS_AW-1:0] slot_addr;
    logic [amt_pkg::LS_AW-1:0] cen_addr;
    logic [amt_pkg::K_W:0]     cen_rmod_wrap;
    logic [amt_pkg::K_W-1:0]   cen_rmod;
    logic [amt_pkg::COL_W-1:0] cen_col_in;

    assign cen_rmod_wrap = {1'b0, rmod_reg} + {1'b0, k_val} - {1'b0, cen_dist};
    assign cen_rmod      = (rmod_reg >= cen_dist) ? rmod_reg - cen_dist
                                                  : cen_rmod_wrap[amt_pkg::K_W-1:0];
    assign cen_col_in    = col_reg - amt_pkg::COL_W'(cen_dist);
    assign slot_addr     = amt_pkg::LS_AW'({rmod_reg, col_reg});
    assign cen_addr      = amt_pkg::LS_AW'({cen_rmod, cen_col_in});

    // ------------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------------
    logic [amt_pkg::PIX_W-1:0]  s1_pix_reg;
    logic [amt_pkg::ROW_W-1:0]  s1_row_reg;
    logic [amt_pkg::COL_W-1:0]  s1_col_reg;
    logic [amt_pkg::K_W-1:0]    s1_cmod_reg;
    logic [amt_pkg::LS_AW-1:0]  s1_addr_reg;
    logic                       s1_first_row_reg;
    logic                       s1_sub_row_reg;
    logic                       s1_first_col_reg;
    logic                       s1_sub_col_reg;
    logic                       s1_res_reg;
    logic                       s1_last_reg;
    logic                       s1_cs_byp_reg;
    logic [amt_pkg::CSUM_W-1:0] s1_cs_fwd_reg;
    logic                       s1_ls_byp_reg;
    logic [amt_pkg::PIX_W-1:0]  s1_ls_fwd_reg;
    logic [amt_pkg::CSUM_W-1:0] csum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (s_tready) begin
            s1_v_reg <= s_tvalid;
        end
    end

    // The item leaving stage 1 writes back at the same edge that the new item
    // reads, so a read of that same entry takes the written value instead.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg       <= s_tdata[amt_pkg::PIX_W-1:0];
            s1_row_reg       <= row_reg;
            s1_col_reg       <= col_reg;
            s1_cmod_reg      <= cmod_reg;
            s1_addr_reg      <= slot_addr;
            s1_first_row_reg <= (row_reg == '0);
            s1_sub_row_reg   <= (row_reg >= amt_pkg::ROW_W'(k_val));
            s1_first_col_reg <= (col_reg == '0);
            s1_sub_col_reg   <= (col_reg >= amt_pkg::COL_W'(k_val));
            s1_res_reg       <= (row_reg >= amt_pkg::ROW_W'(k_m1)) &&
                                (col_reg >= amt_pkg::COL_W'(k_m1));
            s1_last_reg      <= (row_reg == h_last) && (col_reg == w_last);
            s1_cs_byp_reg    <= s1_xfer && (s1_col_reg == col_reg);
            s1_cs_fwd_reg    <= csum;
            s1_ls_byp_reg    <= s1_xfer && (s1_addr_reg == slot_addr);
            s1_ls_fwd_reg    <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Memories: line store (one write, two reads) and column sums.
    // ------------------------------------------------------------------------
    logic [amt_pkg::PIX_W-1:0]  line_store_mem [amt_pkg::LS_DEPTH];
    logic [amt_pkg::CSUM_W-1:0] col_sum_mem    [amt_pkg::MAX_WIDTH];
    logic [amt_pkg::PIX_W-1:0]  ls_old_q;
    logic [amt_pkg::PIX_W-1:0]  ls_cen_q;
    logic [amt_pkg::CSUM_W-1:0] cs_q;

    always_ff @(posedge aclk) begin
        if (s1_xfer) begin
            line_store_mem[s1_addr_reg] <= s1_pix_reg;
            col_sum_mem[s1_col_reg]     <= csum;
        end
        if (accept) begin
            ls_old_q <= line_store_mem[slot_addr];
            ls_cen_q <= line_store_mem[cen_addr];
            cs_q     <= col_sum_mem[col_reg];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1 arithmetic: column sum, then window sum over the last K column
    // sums of the row (kept in a small ring of registers).
    // ------------------------------------------------------------------------
    logic [amt_pkg::CSUM_W-1:0] col_win_reg [amt_pkg::MAX_WINDOW];
    logic [amt_pkg::WSUM_W-1:0] wsum_reg, wsum_next;
    logic [amt_pkg::CSUM_W-1:0] cs_old;
    logic [amt_pkg::PIX_W-1:0]  ls_old;
    logic [amt_pkg::CSUM_W:0]   csum_full;
    logic [amt_pkg::CSUM_W-1:0] cw_old;
    logic [amt_pkg::WSUM_W:0]   wsum_full;
    logic [amt_pkg::PIX_W-1:0]  centre;

    assign cs_old = s1_cs_byp_reg ? s1_cs_fwd_reg : cs_q;
    assign ls_old = s1_ls_byp_reg ? s1_ls_fwd_reg : ls_old_q;

    assign csum_full = (s1_first_row_reg ? '0 : {1'b0, cs_old})
                     - (s1_sub_row_reg ? (amt_pkg::CSUM_W+1)'(ls_old) : '0)
                     + (amt_pkg::CSUM_W+1)'(s1_pix_reg);
    assign csum      = csum_full[amt_pkg::CSUM_W-1:0];

    assign cw_old    = col_win_reg[s1_cmod_reg];
    assign wsum_full = (s1_first_col_reg ? '0 : {1'b0, wsum_reg})
                     - (s1_sub_col_reg ? (amt_pkg::WSUM_W+1)'(cw_old) : '0)
                     + (amt_pkg::WSUM_W+1)'(csum);
    assign wsum_next = wsum_full[amt_pkg::WSUM_W-1:0];

    // With K of 1 or 2 the centre is the pixel just taken
    assign centre = (cen_dist == '0) ? s1_pix_reg : ls_cen_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsum_reg <= '0;
        end else if (s1_xfer) begin
            wsum_reg <= wsum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_xfer) begin
            col_win_reg[s1_cmod_reg] <= csum;
        end
    end

    always_comb begin
        s2_next.res    = s1_res_reg;
        s2_next.last   = s1_last_reg;
        s2_next.row    = s1_row_reg - amt_pkg::ROW_W'(cen_dist);
        s2_next.col    = s1_col_reg - amt_pkg::COL_W'(cen_dist);
        s2_next.centre = centre;
        s2_next.wsum   = wsum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (s2_free) begin
            s2_v_reg <= s1_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_xfer) begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------------
    // Compare stage: (centre + offset) * K*K > window sum, exact in integers.
    // ------------------------------------------------------------------------
    logic signed [amt_pkg::OFF_W:0]    cen_plus_off;
    logic signed [amt_pkg::PROD_W-1:0] lhs;
    logic                              above;

    assign cen_plus_off = $signed({2'b00, s2_reg.centre})
                        + $signed({offset_reg[amt_pkg::OFF_W-1], offset_reg});
    assign lhs   = amt_pkg::PROD_W'(cen_plus_off)
                 * amt_pkg::PROD_W'($signed({1'b0, k_sq}));
    assign above = lhs > $signed(amt_pkg::PROD_W'(s2_reg.wsum));

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic [amt_pkg::ROW_W-1:0] out_row_reg;
    logic [amt_pkg::COL_W-1:0] out_col_reg;
    logic [amt_pkg::PIX_W-1:0] out_bin_reg;
    logic                      out_last_reg;
    logic                      out_load;

    assign out_load = s2_v_reg && s2_reg.res && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_free) begin
            out_v_reg <= s2_v_reg && s2_reg.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg  <= s2_reg.row;
            out_col_reg  <= s2_reg.col;
            out_bin_reg  <= above ? amt_pkg::BIN_HIGH : amt_pkg::BIN_LOW;
            out_last_reg <= s2_reg.last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = amt_pkg::M_TDATA_W'({out_bin_reg, out_col_reg, out_row_reg});

endmodule
